// ===== rtl/core/csct_pkg.sv =====
// csct_pkg: shared constants and types of the circle contact test pipeline
// no dependencies; imported by circle_shape_contact_test and tb
`timescale 1ns / 1ps

package csct_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int RADIUS_W             = 22;
  localparam int NORM_W               = 16;

  // normalized square window, root and carried shifted-magnitude widths
  localparam int WIN_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int SQREM_W = 34;
  localparam int AXK_W   = 32;

  localparam int SQ_ITERS = 31;
  localparam int SQ_PER   = 2;
  localparam int SQ_ST    = (SQ_ITERS + SQ_PER - 1) / SQ_PER;
  localparam int DV_PER   = 2;

  typedef enum logic [1:0] {
    NRM_ZERO   = 2'd0,
    NRM_UNIT   = 2'd1,
    NRM_AXIS_X = 2'd2,
    NRM_AXIS_Y = 2'd3
  } nrm_mode_t;

  // what travels beside the root and quotient datapaths
  typedef struct packed {
    logic               hit;
    nrm_mode_t          mode;
    logic               neg_x;
    logic               neg_y;
    logic [AXK_W-1:0]   axk;
    logic [AXK_W-1:0]   ayk;
  } side_t;

  typedef struct packed {
    logic [WIN_W-1:0]   x;
    logic [SQREM_W-1:0] rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

endpackage

// ===== rtl/core/circle_shape_contact_test.sv =====
// circle_shape_contact_test: pipelined circle-circle / circle-box contact test
// depends on csct_pkg (widths, normal mode codes, carried structs)
`timescale 1ns / 1ps

// throughput: one request per cycle while the result side is not stalled; the 31-step square root
//   and the quotient steps are unrolled two per register stage
// any stall of the result side freezes the whole pipeline at once
// reset: synchronous active-low rst_n clears every stage valid bit; payload keeps its value
module circle_shape_contact_test #(
  parameter int COORD_WIDTH      = csct_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = csct_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [COORD_WIDTH-1:0]       in_first_x,
  input  logic signed [COORD_WIDTH-1:0]       in_first_y,
  input  logic signed [COORD_WIDTH-1:0]       in_second_x,
  input  logic signed [COORD_WIDTH-1:0]       in_second_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_hi_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_hi_y,
  input  logic [csct_pkg::RADIUS_W-1:0]       in_radius_first,
  input  logic [csct_pkg::RADIUS_W-1:0]       in_radius_second,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic signed [csct_pkg::NORM_W-1:0]  out_normal_x,
  output logic signed [csct_pkg::NORM_W-1:0]  out_normal_y
);
  import csct_pkg::*;

  localparam int DW    = COORD_WIDTH + 1;          // signed differences
  localparam int AW    = COORD_WIDTH + 1;          // magnitudes
  localparam int RW    = RADIUS_W + 1;             // radius sum
  localparam int SW    = 2 * AW + 1;               // squared distance
  localparam int RQW   = 2 * RW;                   // squared radius
  localparam int CMPW  = (AW > RW) ? AW : RW;
  localparam int CMP2W = (SW > RQW) ? SW : RQW;
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int QW    = F + 2;                    // quotient bits
  localparam int NUMW  = AXK_W + F + 1;            // rounded numerator
  localparam int DV_ST = (QW + DV_PER - 1) / DV_PER;
  localparam int DREM_W = ROOT_W + 1;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QW-1:0]     bits;
    logic [QW-1:0]     q;
  } dv_t;

  // global stall: the pipeline moves whenever the result register can take data
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // stage 1: differences, box clamp, radius sum
  // ---------------------------------------------------------------------------
  logic                          s1_v_r, s1_func_r;
  logic signed [COORD_WIDTH-1:0] s1_cx_r, s1_cy_r, s1_px_r, s1_py_r;
  logic signed [DW-1:0]          s1_dcx_r, s1_dcy_r, s1_dux_r, s1_duy_r;
  logic [RADIUS_W-1:0]           s1_r1_r;
  logic [RW-1:0]                 s1_rs_r;
  logic signed [COORD_WIDTH-1:0] tx_nxt, ty_nxt, px_nxt, py_nxt;

  // clamp: min against the upper bound first, then max against the lower one
  always_comb begin
    tx_nxt = (in_first_x < in_box_hi_x) ? in_first_x : in_box_hi_x;
    ty_nxt = (in_first_y < in_box_hi_y) ? in_first_y : in_box_hi_y;
    px_nxt = (tx_nxt > in_second_x) ? tx_nxt : in_second_x;
    py_nxt = (ty_nxt > in_second_y) ? ty_nxt : in_second_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r <= in_func;
      s1_cx_r   <= in_first_x;
      s1_cy_r   <= in_first_y;
      s1_px_r   <= px_nxt;
      s1_py_r   <= py_nxt;
      s1_dcx_r  <= DW'(in_first_x) - DW'(in_second_x);
      s1_dcy_r  <= DW'(in_first_y) - DW'(in_second_y);
      s1_dux_r  <= DW'(in_first_x) - DW'(in_box_hi_x);
      s1_duy_r  <= DW'(in_first_y) - DW'(in_box_hi_y);
      s1_r1_r   <= in_radius_first;
      s1_rs_r   <= RW'(in_radius_first) + RW'(in_radius_second);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: contact vector, magnitudes, side distances for the inside case
  // ---------------------------------------------------------------------------
  logic                 s2_v_r, s2_func_r, s2_zr_r, s2_negx_r, s2_negy_r;
  logic                 s2_sgx_r, s2_sgy_r;
  logic [AW-1:0]        s2_ax_r, s2_ay_r, s2_lx_r, s2_ux_r, s2_ly_r, s2_uy_r;
  logic [RW-1:0]        s2_rad_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt;
  logic signed [DW:0]   midx_nxt, midy_nxt;

  function automatic logic [AW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] u;
    u   = v[DW-1] ? $unsigned(-v) : $unsigned(v);
    mag = AW'(u);
  endfunction

  always_comb begin
    dx_nxt   = s1_func_r ? (DW'(s1_cx_r) - DW'(s1_px_r)) : s1_dcx_r;
    dy_nxt   = s1_func_r ? (DW'(s1_cy_r) - DW'(s1_py_r)) : s1_dcy_r;
    // 2c - lo - hi, positive when the center sits in the upper half
    midx_nxt = (DW + 1)'(s1_dcx_r) + (DW + 1)'(s1_dux_r);
    midy_nxt = (DW + 1)'(s1_dcy_r) + (DW + 1)'(s1_duy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_func_r <= s1_func_r;
      s2_ax_r   <= mag(dx_nxt);
      s2_ay_r   <= mag(dy_nxt);
      s2_negx_r <= dx_nxt[DW-1];
      s2_negy_r <= dy_nxt[DW-1];
      s2_zr_r   <= (dx_nxt == '0) && (dy_nxt == '0);
      s2_rad_r  <= s1_func_r ? RW'(s1_r1_r) : s1_rs_r;
      s2_lx_r   <= mag(s1_dcx_r);
      s2_ux_r   <= mag(s1_dux_r);
      s2_ly_r   <= mag(s1_dcy_r);
      s2_uy_r   <= mag(s1_duy_r);
      s2_sgx_r  <= !midx_nxt[DW] && (midx_nxt != '0);
      s2_sgy_r  <= !midy_nxt[DW] && (midy_nxt != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: squares and per-axis bounds
  // ---------------------------------------------------------------------------
  logic                s3_v_r, s3_func_r, s3_zr_r, s3_negx_r, s3_negy_r;
  logic                s3_sgx_r, s3_sgy_r, s3_inx_r, s3_iny_r, s3_xnear_r;
  logic [2*AW-1:0]     s3_sqx_r, s3_sqy_r;
  logic [RQW-1:0]      s3_rsq_r;
  logic [AW-1:0]       s3_ax_r, s3_ay_r;
  logic [AW-1:0]       mx_nxt, my_nxt;

  always_comb begin
    mx_nxt = (s2_lx_r < s2_ux_r) ? s2_lx_r : s2_ux_r;
    my_nxt = (s2_ly_r < s2_uy_r) ? s2_ly_r : s2_uy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_func_r  <= s2_func_r;
      s3_zr_r    <= s2_zr_r;
      s3_negx_r  <= s2_negx_r;
      s3_negy_r  <= s2_negy_r;
      s3_sgx_r   <= s2_sgx_r;
      s3_sgy_r   <= s2_sgy_r;
      s3_ax_r    <= s2_ax_r;
      s3_ay_r    <= s2_ay_r;
      s3_sqx_r   <= s2_ax_r * s2_ax_r;
      s3_sqy_r   <= s2_ay_r * s2_ay_r;
      s3_rsq_r   <= s2_rad_r * s2_rad_r;
      // box test touches at equality, circle test needs strict overlap
      s3_inx_r   <= s2_func_r ? (CMPW'(s2_ax_r) <= CMPW'(s2_rad_r))
                              : (CMPW'(s2_ax_r) <  CMPW'(s2_rad_r));
      s3_iny_r   <= s2_func_r ? (CMPW'(s2_ay_r) <= CMPW'(s2_rad_r))
                              : (CMPW'(s2_ay_r) <  CMPW'(s2_rad_r));
      s3_xnear_r <= mx_nxt < my_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: squared distance, hit decision, normal kind
  // ---------------------------------------------------------------------------
  logic          s4_v_r;
  side_t         s4_side_r;
  logic [SW-1:0] s4_s_r;
  logic [SW-1:0] s_nxt;
  logic          hit_nxt;
  side_t         side_nxt;

  always_comb begin
    s_nxt   = SW'(s3_sqx_r) + SW'(s3_sqy_r);
    hit_nxt = s3_inx_r && s3_iny_r &&
              (s3_func_r ? (CMP2W'(s_nxt) <= CMP2W'(s3_rsq_r))
                         : (CMP2W'(s_nxt) <  CMP2W'(s3_rsq_r)));
    side_nxt.hit   = hit_nxt;
    side_nxt.axk   = AXK_W'(s3_ax_r);
    side_nxt.ayk   = AXK_W'(s3_ay_r);
    side_nxt.neg_x = s3_negx_r;
    side_nxt.neg_y = s3_negy_r;
    side_nxt.mode  = NRM_UNIT;
    priority if (!hit_nxt) begin
      side_nxt.mode = NRM_ZERO;
    end else if (s3_zr_r && s3_func_r) begin
      // center inside the box: nearer side's axis normal
      side_nxt.mode  = s3_xnear_r ? NRM_AXIS_X : NRM_AXIS_Y;
      side_nxt.neg_x = !s3_sgx_r;
      side_nxt.neg_y = !s3_sgy_r;
    end else if (s3_zr_r) begin
      // coincident circle centers
      side_nxt.mode = NRM_ZERO;
    end else begin
      side_nxt.mode = NRM_UNIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= side_nxt;
      s4_s_r    <= s_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 5-6: shift the squared distance by 4^k into [2^60, 2^62),
  // magnitudes follow by 2^k so the later quotient needs no k
  // ---------------------------------------------------------------------------
  logic             s5_v_r;
  side_t            s5_side_r;
  logic [WIN_W-1:0] s5_w_r;
  logic [WIN_W-1:0] w5_nxt, w6_nxt;
  side_t            sd5_nxt, sd6_nxt;

  always_comb begin
    w5_nxt  = WIN_W'(s4_s_r);
    sd5_nxt = s4_side_r;
    if (w5_nxt[WIN_W-1 -: 32] == '0) begin
      w5_nxt      = w5_nxt << 32;
      sd5_nxt.axk = sd5_nxt.axk << 16;
      sd5_nxt.ayk = sd5_nxt.ayk << 16;
    end
    if (w5_nxt[WIN_W-1 -: 16] == '0) begin
      w5_nxt      = w5_nxt << 16;
      sd5_nxt.axk = sd5_nxt.axk << 8;
      sd5_nxt.ayk = sd5_nxt.ayk << 8;
    end
    if (w5_nxt[WIN_W-1 -: 8] == '0) begin
      w5_nxt      = w5_nxt << 8;
      sd5_nxt.axk = sd5_nxt.axk << 4;
      sd5_nxt.ayk = sd5_nxt.ayk << 4;
    end
  end

  always_comb begin
    w6_nxt  = s5_w_r;
    sd6_nxt = s5_side_r;
    if (w6_nxt[WIN_W-1 -: 4] == '0) begin
      w6_nxt      = w6_nxt << 4;
      sd6_nxt.axk = sd6_nxt.axk << 2;
      sd6_nxt.ayk = sd6_nxt.ayk << 2;
    end
    if (w6_nxt[WIN_W-1 -: 2] == '0) begin
      w6_nxt      = w6_nxt << 2;
      sd6_nxt.axk = sd6_nxt.axk << 1;
      sd6_nxt.ayk = sd6_nxt.ayk << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= sd5_nxt;
      s5_w_r    <= w5_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // square root: digit-by-digit, SQ_PER result bits per stage
  // ---------------------------------------------------------------------------
  logic  sq_v_r    [0:SQ_ST];
  side_t sq_side_r [0:SQ_ST];
  sq_t   sq_r      [0:SQ_ST];

  function automatic sq_t sq_iter(input sq_t a);
    logic [SQREM_W-1:0] r;
    logic [SQREM_W-1:0] t;
    r = {a.rem[SQREM_W-3:0], a.x[WIN_W-1 -: 2]};
    t = SQREM_W'({a.root, 2'b01});
    sq_iter.x = a.x << 2;
    if (r >= t) begin
      sq_iter.rem  = r - t;
      sq_iter.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_iter.rem  = r;
      sq_iter.root = {a.root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0]  <= sd6_nxt;
      sq_r[0].x     <= w6_nxt;
      sq_r[0].rem   <= '0;
      sq_r[0].root  <= '0;
    end
  end

  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    sq_t nxt;

    always_comb begin
      nxt = sq_r[g];
      for (int j = 0; j < SQ_PER; j++) begin
        if (g * SQ_PER + j < SQ_ITERS) begin
          nxt = sq_iter(nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[g+1] <= sq_v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[g+1] <= sq_side_r[g];
        sq_r[g+1]      <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rounded quotients |d|*2^(F+k) + L/2 over L, one lane per axis
  // ---------------------------------------------------------------------------
  logic              dv_v_r    [0:DV_ST];
  side_t             dv_side_r [0:DV_ST];
  logic [ROOT_W-1:0] dv_len_r  [0:DV_ST];
  dv_t               dvx_r     [0:DV_ST];
  dv_t               dvy_r     [0:DV_ST];
  logic [NUMW-1:0]   numx_nxt, numy_nxt;
  logic [ROOT_W-1:0] len_nxt;

  function automatic dv_t dv_iter(input dv_t a, input logic [ROOT_W-1:0] len);
    logic [DREM_W-1:0] r;
    r = {a.rem[DREM_W-2:0], a.bits[QW-1]};
    dv_iter.bits = a.bits << 1;
    if (r >= DREM_W'(len)) begin
      dv_iter.rem = r - DREM_W'(len);
      dv_iter.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      dv_iter.rem = r;
      dv_iter.q   = {a.q[QW-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    len_nxt  = sq_r[SQ_ST].root;
    numx_nxt = {1'b0, sq_side_r[SQ_ST].axk, {F{1'b0}}} + NUMW'(len_nxt >> 1);
    numy_nxt = {1'b0, sq_side_r[SQ_ST].ayk, {F{1'b0}}} + NUMW'(len_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_ST];
    end
  end

  // the high part of the numerator is already below L
  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0]  <= sq_side_r[SQ_ST];
      dv_len_r[0]   <= len_nxt;
      dvx_r[0].rem  <= DREM_W'(numx_nxt >> QW);
      dvx_r[0].bits <= numx_nxt[QW-1:0];
      dvx_r[0].q    <= '0;
      dvy_r[0].rem  <= DREM_W'(numy_nxt >> QW);
      dvy_r[0].bits <= numy_nxt[QW-1:0];
      dvy_r[0].q    <= '0;
    end
  end

  for (genvar g = 0; g < DV_ST; g++) begin : g_div
    dv_t nx_nxt, ny_nxt;

    always_comb begin
      nx_nxt = dvx_r[g];
      ny_nxt = dvy_r[g];
      for (int j = 0; j < DV_PER; j++) begin
        if (g * DV_PER + j < QW) begin
          nx_nxt = dv_iter(nx_nxt, dv_len_r[g]);
          ny_nxt = dv_iter(ny_nxt, dv_len_r[g]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[g+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[g+1] <= dv_v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[g+1] <= dv_side_r[g];
        dv_len_r[g+1]  <= dv_len_r[g];
        dvx_r[g+1]     <= nx_nxt;
        dvy_r[g+1]     <= ny_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register: clamp to one, apply signs, pick the normal kind
  // ---------------------------------------------------------------------------
  localparam logic [QW-1:0] ONE = QW'(1) << F;

  logic               out_valid_r, out_hit_r;
  logic [NORM_W-1:0]  out_nx_r, out_ny_r;
  logic [QW-1:0]      qx_nxt, qy_nxt;
  logic signed [31:0] one_s, nx_nxt, ny_nxt;
  side_t              fs;

  always_comb begin
    fs     = dv_side_r[DV_ST];
    qx_nxt = (dvx_r[DV_ST].q > ONE) ? ONE : dvx_r[DV_ST].q;
    qy_nxt = (dvy_r[DV_ST].q > ONE) ? ONE : dvy_r[DV_ST].q;
    one_s  = 32'sd1 <<< F;
    unique case (fs.mode)
      NRM_UNIT: begin
        nx_nxt = fs.neg_x ? -$signed(32'(qx_nxt)) : $signed(32'(qx_nxt));
        ny_nxt = fs.neg_y ? -$signed(32'(qy_nxt)) : $signed(32'(qy_nxt));
      end
      NRM_AXIS_X: begin
        nx_nxt = fs.neg_x ? -one_s : one_s;
        ny_nxt = '0;
      end
      NRM_AXIS_Y: begin
        nx_nxt = '0;
        ny_nxt = fs.neg_y ? -one_s : one_s;
      end
      default: begin
        nx_nxt = '0;
        ny_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[DV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= fs.hit;
      out_nx_r  <= nx_nxt[NORM_W-1:0];
      out_ny_r  <= ny_nxt[NORM_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_normal_x = $signed(out_nx_r);
  assign out_normal_y = $signed(out_ny_r);

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for circle_shape_contact_test (circle-circle and circle-box)
// depends on csct_pkg and circle_shape_contact_test; predicts contact results in-bench
`timescale 1ns / 1ps

module tb;
  import csct_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = NORMAL_FRAC_BITS_DEF;
  localparam int LATENCY = 32;
  localparam logic FUNC_CIRCLE = 1'b0;
  localparam logic FUNC_BOX    = 1'b1;

  // one contact request
  typedef struct {
    logic                 func;
    logic signed [CW-1:0] fx, fy, sx, sy, hx, hy;
    logic [RADIUS_W-1:0]  r1, r2;
  } pair_t;

  // one contact result
  typedef struct {
    logic              hit;
    logic [NORM_W-1:0] nx, ny;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic signed [CW-1:0] in_first_x = '0, in_first_y = '0, in_second_x = '0;
  logic signed [CW-1:0] in_second_y = '0, in_box_hi_x = '0, in_box_hi_y = '0;
  logic [RADIUS_W-1:0] in_radius_first = '0, in_radius_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       mismatches = 0;
  bit       calm = 1'b0;       // last part of the run: no idling
  bit       drain_hold = 1'b0; // sender pauses until every result is back
  bit       in_taken = 1'b0;   // request accepted at the last rising edge
  int       hold_off = 0;      // long receiver stall, counted down
  int       send_gap = 0, recv_gap = 0;

  always #10 clk = ~clk;

  circle_shape_contact_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_box_hi_x(in_box_hi_x), .in_box_hi_y(in_box_hi_y),
    .in_radius_first(in_radius_first), .in_radius_second(in_radius_second),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y)
  );

  // integer square root of a 64-bit value, bit by bit
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded unit vector in fixed point, after scaling the squared length up
  function automatic void unit_normal(longint dx, longint dy, output longint nx,
                                      output longint ny);
    longint unsigned ax, ay, s, len, qx, qy, one;
    int k;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = ax * ax + ay * ay;
    one = 64'd1 << FB;
    nx = 0;
    ny = 0;
    if (s == 0) return;
    k = 0;
    while (k < 30 && (s >> (60 - 2 * k)) == 0) k++;
    len = root64(s << (2 * k));
    qx = ((ax << (FB + k)) + len / 2) / len;
    qy = ((ay << (FB + k)) + len / 2) / len;
    if (qx > one) qx = one;
    if (qy > one) qy = one;
    nx = dx < 0 ? -longint'(qx) : longint'(qx);
    ny = dy < 0 ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // expected contact for one request
  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint cx, cy, sx, sy, hx, hy, px, py, dx, dy, nx, ny, r1, rs, one;
    longint mx, my;
    cx = p.fx; cy = p.fy; sx = p.sx; sy = p.sy; hx = p.hx; hy = p.hy;
    r1 = p.r1;
    rs = longint'(p.r1) + longint'(p.r2);
    one = longint'(1) << FB;
    nx = 0;
    ny = 0;
    c.hit = 1'b0;
    if (p.func == FUNC_CIRCLE) begin
      dx = cx - sx;
      dy = cy - sy;
      if (mag(dx) < rs && mag(dy) < rs && dx * dx + dy * dy < rs * rs) begin
        c.hit = 1'b1;
        unit_normal(dx, dy, nx, ny);
      end
    end else begin
      // clamp: min with upper bound, then max with lower bound
      px = cx < hx ? cx : hx;
      px = px > sx ? px : sx;
      py = cy < hy ? cy : hy;
      py = py > sy ? py : sy;
      dx = cx - px;
      dy = cy - py;
      if (mag(dx) <= r1 && mag(dy) <= r1 && dx * dx + dy * dy <= r1 * r1) begin
        c.hit = 1'b1;
        if (dx != 0 || dy != 0) begin
          unit_normal(dx, dy, nx, ny);
        end else begin
          // center inside: push out through the nearer side
          mx = mag(cx - sx) < mag(cx - hx) ? mag(cx - sx) : mag(cx - hx);
          my = mag(cy - sy) < mag(cy - hy) ? mag(cy - sy) : mag(cy - hy);
          if (mx < my) nx = (2 * cx > sx + hx) ? one : -one;
          else ny = (2 * cy > sy + hy) ? one : -one;
        end
      end
    end
    c.nx = nx[NORM_W-1:0];
    c.ny = ny[NORM_W-1:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // append one request to the pending list
  task automatic enqueue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // request acceptance, seen at the rising edge itself
  always @(posedge clk) begin
    pair_t taken;
    if (rst_n && in_valid && in_ready) begin
      taken = pending_pairs.pop_front();
      expected_contacts.insert(expected_contacts.size(), predict_contact(taken));
      in_taken = 1'b1;
    end else begin
      in_taken = 1'b0;
    end
  end

  // driver: present the next queued request at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) send_gap--;
        if (pending_pairs.size() > 0 && send_gap == 0 && !drain_hold
            && !(in_taken && !calm && $urandom_range(0, 9) == 0)) begin
          in_valid <= 1'b1;
          in_func <= pending_pairs[0].func;
          in_first_x <= pending_pairs[0].fx;
          in_first_y <= pending_pairs[0].fy;
          in_second_x <= pending_pairs[0].sx;
          in_second_y <= pending_pairs[0].sy;
          in_box_hi_x <= pending_pairs[0].hx;
          in_box_hi_y <= pending_pairs[0].hy;
          in_radius_first <= pending_pairs[0].r1;
          in_radius_second <= pending_pairs[0].r2;
        end else begin
          in_valid <= 1'b0;
          if (send_gap == 0 && !calm && pending_pairs.size() > 0)
            send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver readiness: random stall bursts, plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    contact_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_contacts.size() == 0) begin
        $display("error: unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_contacts.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_normal_x !== want.nx)
          report_mismatch("normal_x", out_normal_x, $signed(want.nx));
        if (out_normal_y !== want.ny)
          report_mismatch("normal_y", out_normal_y, $signed(want.ny));
      end
    end
  end

  function automatic logic signed [CW-1:0] rnd_coord();
    return CW'($urandom);
  endfunction

  function automatic pair_t mk(logic f, longint fx, longint fy, longint sx, longint sy,
                               longint hx, longint hy, longint r1, longint r2);
    pair_t p;
    p.func = f;
    p.fx = CW'(fx); p.fy = CW'(fy); p.sx = CW'(sx); p.sy = CW'(sy);
    p.hx = CW'(hx); p.hy = CW'(hy);
    p.r1 = RADIUS_W'(r1); p.r2 = RADIUS_W'(r2);
    return p;
  endfunction

  // random request: mostly near contact so hits and misses both occur
  function automatic pair_t rnd_pair();
    pair_t p;
    int spread, lo, hi, t;
    p.func = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: spread = 255;
      1: spread = 65535;
      2: spread = 4194303;
      default: spread = 0;
    endcase
    p.fx = rnd_coord();
    p.fy = rnd_coord();
    if (spread == 0) begin
      // full-range noise, radii of any size
      p.sx = rnd_coord(); p.sy = rnd_coord();
      p.hx = rnd_coord(); p.hy = rnd_coord();
      p.r1 = RADIUS_W'($urandom);
      p.r2 = RADIUS_W'($urandom);
    end else begin
      p.sx = CW'(p.fx + $signed($urandom_range(0, 2 * spread)) - spread);
      p.sy = CW'(p.fy + $signed($urandom_range(0, 2 * spread)) - spread);
      p.r1 = RADIUS_W'($urandom_range(0, spread));
      p.r2 = RADIUS_W'($urandom_range(0, spread));
      lo = p.sx; t = $urandom_range(0, spread); hi = lo + t;
      p.hx = CW'(hi);
      lo = p.sy; t = $urandom_range(0, spread); hi = lo + t;
      p.hy = CW'(hi);
      // sometimes put the lower corner below the center so it may sit inside
      if ($urandom_range(0, 2) == 0) begin
        p.sx = CW'(p.fx - $signed($urandom_range(0, spread)));
        p.sy = CW'(p.fy - $signed($urandom_range(0, spread)));
        p.hx = CW'(p.fx + $signed($urandom_range(0, spread)));
        p.hy = CW'(p.fy + $signed($urandom_range(0, spread)));
      end
    end
    return p;
  endfunction

  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;
  localparam longint RMAX = 4194303;

  initial begin
    int n;
    // directed: extremes and the special cases
    enqueue_pair(mk(FUNC_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_pair(mk(FUNC_CIRCLE, 5, 5, 5, 5, 0, 0, 1, 0));        // same centers
    enqueue_pair(mk(FUNC_CIRCLE, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, RMAX, RMAX));
    enqueue_pair(mk(FUNC_CIRCLE, CMIN, 0, CMIN + 100, 0, 0, 0, 50, 50)); // touching
    enqueue_pair(mk(FUNC_CIRCLE, 0, 0, 30, 40, 0, 0, 25, 26));
    enqueue_pair(mk(FUNC_CIRCLE, 0, 0, 30, 40, 0, 0, 25, 25));
    enqueue_pair(mk(FUNC_CIRCLE, -RMAX, -RMAX, RMAX, RMAX, 0, 0, RMAX, RMAX));
    enqueue_pair(mk(FUNC_BOX, 0, 0, -10, -10, 10, 10, 0, 0));       // inside, tie
    enqueue_pair(mk(FUNC_BOX, 8, 0, -10, -10, 10, 10, 0, RMAX));    // inside, +x
    enqueue_pair(mk(FUNC_BOX, -8, 1, -10, -10, 10, 10, 0, 0));      // inside, -x
    enqueue_pair(mk(FUNC_BOX, 0, 9, -10, -10, 10, 10, 0, 0));       // inside, +y
    enqueue_pair(mk(FUNC_BOX, 1, -9, -10, -10, 10, 10, 0, 0));      // inside, -y
    enqueue_pair(mk(FUNC_BOX, 13, 14, -10, -10, 10, 10, 5, 0));     // corner, on r
    enqueue_pair(mk(FUNC_BOX, 13, 14, -10, -10, 10, 10, 4, 0));     // corner, miss
    enqueue_pair(mk(FUNC_BOX, 0, 0, 10, 10, -10, -10, 20, 0));      // inverted box
    enqueue_pair(mk(FUNC_BOX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, RMAX, RMAX));
    enqueue_pair(mk(FUNC_BOX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, RMAX, 0));
    enqueue_pair(mk(FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0));             // point box
    enqueue_pair(mk(FUNC_BOX, -1, -1, -1, -1, -1, -1, RMAX, RMAX));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first random chunk with idling on both sides
    repeat (300) enqueue_pair(rnd_pair());
    wait (pending_pairs.size() == 0);

    // long receiver hold-off while the sender keeps offering
    repeat (150) enqueue_pair(rnd_pair());
    @(negedge clk);
    hold_off = 100;
    wait (pending_pairs.size() == 0);

    // sender pauses until every result is back
    @(negedge clk);
    drain_hold = 1'b1;
    wait (expected_contacts.size() == 0 && !in_valid);
    @(negedge clk);
    drain_hold = 1'b0;

    repeat (300) enqueue_pair(rnd_pair());
    wait (pending_pairs.size() == 0);

    // last part: no idling
    calm = 1'b1;
    repeat (200) enqueue_pair(rnd_pair());
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (expected_contacts.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    n = expected_contacts.size() + mismatches;
    if (n == 0) begin
      $display("circle_shape_contact_test: match");
    end else begin
      $display("circle_shape_contact_test: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("circle_shape_contact_test: mismatch");
    $finish;
  end

endmodule
